>>> design/svr_pkg.sv
package svr_pkg;

  localparam int unsigned GAIN_W    = 17;
  localparam int unsigned LEVEL_W   = 16;
  localparam int unsigned STEP_W    = 32;
  localparam int unsigned MUL_A_W   = 32;
  localparam int unsigned MUL_B_W   = 24;
  localparam int unsigned PROD_W    = MUL_A_W + MUL_B_W;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned PADDR_W   = 4;
  localparam int unsigned PDATA_W   = 32;

  // Unity release gain in Q1.16
  localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;

  // Exact floor(p / 127) for p < 2^23 as (p * RECIP_127) >> RECIP_SHIFT
  localparam logic [MUL_B_W-1:0] RECIP_127   = 24'd8454661;
  localparam int unsigned        RECIP_SHIFT = 30;

  // Step product is shifted right by this minus the octave
  localparam logic [4:0] STEP_SHIFT_BASE = 5'd22;

  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam logic [31:0] A4_INC_RST  = 32'd39370534;
  localparam logic [15:0] SCALE_RST   = 16'd9830;
  localparam logic [15:0] FACTOR_RST  = 16'd64881;
  localparam logic [16:0] FLOOR_RST   = 17'd328;

  typedef enum logic [1:0] {
    OP_TICK        = 2'd0,
    OP_NOTE_ON     = 2'd1,
    OP_OFF_RELEASE = 2'd2,
    OP_OFF_NOW     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_A4_INC = 2'd0,
    REG_SCALE  = 2'd1,
    REG_FACTOR = 2'd2,
    REG_FLOOR  = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    SEQ_NEXT     = 2'd0,
    SEQ_END      = 2'd1,
    SEQ_DISPATCH = 2'd2
  } seq_e;

  typedef enum logic [2:0] {
    MUL_NONE        = 3'd0,
    MUL_ROM_LEVEL   = 3'd1,
    MUL_PROD_GAIN   = 3'd2,
    MUL_GAIN_FACTOR = 3'd3,
    MUL_A4_RATIO    = 3'd4,
    MUL_VEL_SCALE   = 3'd5,
    MUL_PROD_RECIP  = 3'd6
  } mul_sel_e;

  typedef struct packed {
    seq_e     seq;
    mul_sel_e mul;
    logic     ld_step;
    logic     ld_note;
    logic     ld_smp;
    logic     adv_phase;
    logic     rel_start;
    logic     kill;
    logic     emit_tick;
    logic     emit_zero;
  } uword_t;

  typedef struct packed {
    logic busy;
    logic out_block;
  } dp_status_t;

  typedef struct packed {
    logic [31:0] a4_inc;
    logic [15:0] level_scale;
    logic [15:0] release_factor;
    logic [16:0] release_floor;
  } cfg_t;

  typedef logic [3:0] upc_t;

  localparam upc_t UA_IDLE = 4'd0;
  localparam upc_t UA_N1   = 4'd1;
  localparam upc_t UA_N2   = 4'd2;
  localparam upc_t UA_N3   = 4'd3;
  localparam upc_t UA_N4   = 4'd4;
  localparam upc_t UA_T1   = 4'd5;
  localparam upc_t UA_T2   = 4'd6;
  localparam upc_t UA_T3   = 4'd7;
  localparam upc_t UA_T4   = 4'd8;
  localparam upc_t UA_Z1   = 4'd9;
  localparam upc_t UA_R1   = 4'd10;
  localparam upc_t UA_K1   = 4'd11;
  localparam upc_t UA_LAST = UA_K1;

  localparam uword_t UW_NOP = '{seq: SEQ_END, mul: MUL_NONE, default: 1'b0};

  function automatic uword_t ucode(upc_t a);
    uword_t w;
    w = UW_NOP;
    case (a)
      UA_IDLE: w.seq = SEQ_DISPATCH;
      UA_N1: begin
        w.seq = SEQ_NEXT;
        w.mul = MUL_A4_RATIO;
      end
      UA_N2: begin
        w.seq     = SEQ_NEXT;
        w.mul     = MUL_VEL_SCALE;
        w.ld_step = 1'b1;
      end
      UA_N3: begin
        w.seq = SEQ_NEXT;
        w.mul = MUL_PROD_RECIP;
      end
      UA_N4: w.ld_note = 1'b1;
      UA_T1: begin
        w.seq = SEQ_NEXT;
        w.mul = MUL_ROM_LEVEL;
      end
      UA_T2: begin
        w.seq = SEQ_NEXT;
        w.mul = MUL_PROD_GAIN;
      end
      UA_T3: begin
        w.seq       = SEQ_NEXT;
        w.mul       = MUL_GAIN_FACTOR;
        w.ld_smp    = 1'b1;
        w.adv_phase = 1'b1;
      end
      UA_T4: w.emit_tick = 1'b1;
      UA_Z1: w.emit_zero = 1'b1;
      UA_R1: w.rel_start = 1'b1;
      UA_K1: w.kill      = 1'b1;
      default: w = UW_NOP;
    endcase
    return w;
  endfunction

  // 2^(k/12) in Q1.16, rounded
  function automatic logic [GAIN_W-1:0] semitone_ratio(logic [3:0] semi);
    logic [GAIN_W-1:0] r;
    case (semi)
      4'd0:    r = 17'd65536;
      4'd1:    r = 17'd69433;
      4'd2:    r = 17'd73562;
      4'd3:    r = 17'd77936;
      4'd4:    r = 17'd82570;
      4'd5:    r = 17'd87480;
      4'd6:    r = 17'd92682;
      4'd7:    r = 17'd98193;
      4'd8:    r = 17'd104032;
      4'd9:    r = 17'd110218;
      4'd10:   r = 17'd116772;
      4'd11:   r = 17'd123715;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

  // Octave of note + 3: divide by 12 as (s * 171) >> 11, exact for s < 256
  function automatic logic [3:0] note_octave(logic [6:0] note);
    logic [7:0]  s;
    logic [15:0] p;
    s = {1'b0, note} + 8'd3;
    p = {8'b0, s} * 16'd171;
    return p[14:11];
  endfunction

  function automatic logic [3:0] note_semitone(logic [6:0] note);
    logic [7:0] s;
    logic [7:0] o12;
    s   = {1'b0, note} + 8'd3;
    o12 = {4'b0, note_octave(note)} * 8'd12;
    return 4'(s - o12);
  endfunction

endpackage

>>> design/svr_sine_rom.sv
module svr_sine_rom import svr_pkg::*; #(
  parameter int unsigned SINE_TABLE_DEPTH = 1024,
  parameter int unsigned SAMPLE_BITS      = 16
) (
  input  logic                                 clk_i,
  input  logic [$clog2(SINE_TABLE_DEPTH)-1:0]  idx_i,
  output logic [SAMPLE_BITS-2:0]               mag_o,
  output logic                                 neg_o
);

  localparam int unsigned AW        = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned QW        = AW - 2;
  localparam int unsigned KW        = QW + 1;
  localparam int unsigned MW        = SAMPLE_BITS - 1;
  localparam int unsigned QUARTER   = SINE_TABLE_DEPTH / 4;
  localparam int unsigned QROM_BITS = (QUARTER + 1) * MW;
  localparam int unsigned ROM_SHIFT = 31 - SAMPLE_BITS;
  localparam logic [63:0] DEPTH64   = 64'(SINE_TABLE_DEPTH);
  localparam logic [63:0] RND       = 64'd1 << (ROM_SHIFT - 1);
  localparam logic [63:0] MAG_MAX   = (64'd1 << MW) - 64'd1;

  // Quarter-wave magnitudes, Taylor series in Q30 truncated at each step
  function automatic logic [QROM_BITS-1:0] build_qrom();
    logic [QROM_BITS-1:0] v;
    logic [63:0]          x;
    logic [63:0]          x2;
    logic [63:0]          t;
    logic [63:0]          s;
    logic [63:0]          m;
    v = '0;
    for (int k = 0; k <= int'(QUARTER); k++) begin
      x  = (64'(k) * 64'd4 * HALF_PI_Q30) / DEPTH64;
      x2 = (x * x) >> 30;
      t  = Q30_ONE - x2 / 64'd110;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      m  = (s + RND) >> ROM_SHIFT;
      if (m > MAG_MAX) begin
        m = MAG_MAX;
      end
      v[k*MW +: MW] = m[MW-1:0];
    end
    return v;
  endfunction

  localparam logic [QROM_BITS-1:0] QROM = build_qrom();

  logic [1:0]    quad;
  logic [QW-1:0] j;
  logic [KW-1:0] k;

  assign quad = idx_i[AW-1 -: 2];
  assign j    = idx_i[QW-1:0];
  // Mirror the index on the falling quarters
  assign k    = quad[0] ? (KW'(QUARTER) - {1'b0, j}) : {1'b0, j};

  always_ff @(posedge clk_i) begin
    mag_o <= QROM[MW*k +: MW];
    neg_o <= quad[1];
  end

endmodule

>>> design/svr_apb_regs.sv
module svr_apb_regs import svr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t     cfg_q;
  cfg_t     cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_A4_INC: cfg_d.a4_inc         = pwdata;
        REG_SCALE:  cfg_d.level_scale    = pwdata[15:0];
        REG_FACTOR: cfg_d.release_factor = pwdata[15:0];
        REG_FLOOR:  cfg_d.release_floor  = pwdata[16:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_A4_INC: prdata = cfg_q.a4_inc;
      REG_SCALE:  prdata = {16'b0, cfg_q.level_scale};
      REG_FACTOR: prdata = {16'b0, cfg_q.release_factor};
      REG_FLOOR:  prdata = {15'b0, cfg_q.release_floor};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.a4_inc         <= A4_INC_RST;
      cfg_q.level_scale    <= SCALE_RST;
      cfg_q.release_factor <= FACTOR_RST;
      cfg_q.release_floor  <= FLOOR_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> design/svr_useq.sv
module svr_useq import svr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] opcode_i,
  input  dp_status_t status_i,
  output logic       in_ready_o,
  output logic       accept_o,
  output uword_t     uw_o,
  output logic       go_o
);

  upc_t   upc_q;
  upc_t   upc_d;
  uword_t uw;
  logic   emit;

  assign uw         = ucode(upc_q);
  assign uw_o       = uw;
  assign in_ready_o = (uw.seq == SEQ_DISPATCH);
  assign accept_o   = in_ready_o & in_valid_i;
  assign emit       = uw.emit_tick | uw.emit_zero;
  // hold an emitting step while the previous result is still unread
  assign go_o       = ~(emit & status_i.out_block);

  always_comb begin
    upc_d = upc_q;
    if (go_o) begin
      case (uw.seq)
        SEQ_NEXT: upc_d = upc_q + upc_t'(1);
        SEQ_END:  upc_d = UA_IDLE;
        SEQ_DISPATCH: begin
          if (accept_o) begin
            case (op_e'(opcode_i))
              OP_TICK:        upc_d = status_i.busy ? UA_T1 : UA_Z1;
              OP_NOTE_ON:     upc_d = UA_N1;
              OP_OFF_RELEASE: upc_d = UA_R1;
              OP_OFF_NOW:     upc_d = UA_K1;
              default:        upc_d = UA_IDLE;
            endcase
          end
        end
        default: upc_d = UA_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UA_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  a_upc_range: assert property (@(posedge clk_i) disable iff (!rst_ni) upc_q <= UA_LAST)
    else $error("step counter outside program");

endmodule

>>> design/svr_datapath.sv
module svr_datapath import svr_pkg::*; #(
  parameter int unsigned SINE_TABLE_DEPTH = 1024,
  parameter int unsigned PHASE_BITS       = 32,
  parameter int unsigned SAMPLE_BITS      = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cfg_t                          cfg_i,
  input  uword_t                        uw_i,
  input  logic                          go_i,
  input  logic                          accept_i,
  input  logic [6:0]                    note_number_i,
  input  logic [6:0]                    velocity_i,
  input  logic                          out_ready_i,
  output dp_status_t                    status_o,
  output logic                          out_valid_o,
  output logic signed [SAMPLE_BITS-1:0] sample_o,
  output logic                          voice_busy_o
);

  localparam int unsigned AW = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned MW = SAMPLE_BITS - 1;

  logic [PHASE_BITS-1:0]  phase_q, phase_d;
  logic [STEP_W-1:0]      step_q, step_d;
  logic [LEVEL_W-1:0]     level_q, level_d;
  logic [GAIN_W-1:0]      gain_q, gain_d;
  logic                   busy_q, busy_d;
  logic                   out_valid_q, out_valid_d;

  logic [6:0]             note_q;
  logic [6:0]             vel_q;
  logic [PROD_W-1:0]      prod_q;
  logic [SAMPLE_BITS-1:0] smp_q;
  logic [SAMPLE_BITS-1:0] out_sample_q;
  logic                   out_busy_q;

  logic [MW-1:0]          rom_mag;
  logic                   rom_neg;
  logic [MUL_A_W-1:0]     mul_a;
  logic [MUL_B_W-1:0]     mul_b;
  logic [PROD_W-1:0]      prod_mul;
  logic [4:0]             step_sh;
  logic [PROD_W-1:0]      step_shifted;
  logic [STEP_W-1:0]      step_sat;
  logic [GAIN_W-1:0]      gain_new;
  logic                   releasing;
  logic                   gain_stop;
  logic [SAMPLE_BITS-1:0] smp_mag;

  svr_sine_rom #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_rom (
    .clk_i(clk_i),
    .idx_i(phase_q[PHASE_BITS-1 -: AW]),
    .mag_o(rom_mag),
    .neg_o(rom_neg)
  );

  // Shared multiplier operand select
  always_comb begin
    case (uw_i.mul)
      MUL_ROM_LEVEL: begin
        mul_a = MUL_A_W'(rom_mag);
        mul_b = MUL_B_W'(level_q);
      end
      MUL_PROD_GAIN: begin
        mul_a = MUL_A_W'(prod_q[PROD_W-1:FRAC_BITS]);
        mul_b = MUL_B_W'(releasing ? gain_q : GAIN_ONE);
      end
      MUL_GAIN_FACTOR: begin
        mul_a = MUL_A_W'(gain_q);
        mul_b = MUL_B_W'(cfg_i.release_factor);
      end
      MUL_A4_RATIO: begin
        mul_a = cfg_i.a4_inc;
        mul_b = MUL_B_W'(semitone_ratio(note_semitone(note_q)));
      end
      MUL_VEL_SCALE: begin
        mul_a = MUL_A_W'(vel_q);
        mul_b = MUL_B_W'(cfg_i.level_scale);
      end
      MUL_PROD_RECIP: begin
        mul_a = MUL_A_W'(prod_q[22:0]);
        mul_b = RECIP_127;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_mul = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Octave shift of the step product, then saturate to 32 bits
  assign step_sh      = STEP_SHIFT_BASE - {1'b0, note_octave(note_q)};
  assign step_shifted = prod_q >> step_sh;
  assign step_sat     = (|step_shifted[PROD_W-1:STEP_W]) ? '1 : step_shifted[STEP_W-1:0];

  assign releasing = (gain_q != '0);
  assign gain_new  = prod_q[FRAC_BITS +: GAIN_W];
  assign gain_stop = (gain_new <= cfg_i.release_floor);
  assign smp_mag   = {1'b0, prod_q[FRAC_BITS +: MW]};

  always_comb begin
    phase_d     = phase_q;
    step_d      = step_q;
    level_d     = level_q;
    gain_d      = gain_q;
    busy_d      = busy_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    if (go_i) begin
      if (uw_i.ld_step) begin
        step_d = step_sat;
      end
      if (uw_i.ld_note) begin
        phase_d = '0;
        level_d = prod_q[RECIP_SHIFT +: LEVEL_W];
        gain_d  = '0;
        busy_d  = 1'b1;
      end
      if (uw_i.adv_phase) begin
        phase_d = phase_q + PHASE_BITS'(step_q);
      end
      if (uw_i.rel_start && busy_q && !releasing) begin
        gain_d = GAIN_ONE;
      end
      if (uw_i.kill) begin
        busy_d = 1'b0;
        step_d = '0;
        gain_d = '0;
      end
      if (uw_i.emit_tick) begin
        out_valid_d = 1'b1;
        if (releasing) begin
          // decay, and stop the voice once at or below the floor
          if (gain_stop) begin
            busy_d = 1'b0;
            step_d = '0;
            gain_d = '0;
          end else begin
            gain_d = gain_new;
          end
        end
      end
      if (uw_i.emit_zero) begin
        out_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      step_q      <= '0;
      level_q     <= '0;
      gain_q      <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      step_q      <= step_d;
      level_q     <= level_d;
      gain_q      <= gain_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      note_q <= note_number_i;
      vel_q  <= velocity_i;
    end
    if (go_i && (uw_i.mul != MUL_NONE)) begin
      prod_q <= prod_mul;
    end
    if (go_i && uw_i.ld_smp) begin
      smp_q <= rom_neg ? (~smp_mag + 1'b1) : smp_mag;
    end
    if (go_i && uw_i.emit_tick) begin
      out_sample_q <= smp_q;
      out_busy_q   <= ~(releasing & gain_stop);
    end
    if (go_i && uw_i.emit_zero) begin
      out_sample_q <= '0;
      out_busy_q   <= 1'b0;
    end
  end

  assign status_o.busy      = busy_q;
  assign status_o.out_block = out_valid_q & ~out_ready_i;
  assign out_valid_o        = out_valid_q;
  assign sample_o           = $signed(out_sample_q);
  assign voice_busy_o       = out_busy_q;

  a_gain_max: assert property (@(posedge clk_i) disable iff (!rst_ni) gain_q <= GAIN_ONE)
    else $error("release gain above unity");

  a_gain_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gain_q != '0) |-> busy_q)
    else $error("release gain held by an idle voice");

  // a note on loads the step before it marks the voice busy, so check at dispatch only
  a_idle_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy_q && (uw_i.seq == SEQ_DISPATCH)) |-> (step_q == '0))
    else $error("idle voice keeps a phase step");

endmodule

>>> design/sine_voice_with_release_core.sv
// Sounding tick: runs steps T1 to T4 and emits its sample at T4; a new item is taken only back at dispatch.
// Idle tick emits a zero sample at Z1; release (R1), note off (K1) and note on (N1 to N4) emit nothing.
// Rate is set by the micro-program: one dispatch step plus up to four steps that
// share a single 32x24 multiplier, with a registered read of the sine table; an unread result holds the emit step.
// Reset (rst_ni low, asynchronous) idles the voice, clears phase, step, level and
// gain, drops the output valid and loads the register defaults.
module sine_voice_with_release_core import svr_pkg::*; #(
  parameter int unsigned SINE_TABLE_DEPTH = 1024,
  parameter int unsigned PHASE_BITS       = 32,
  parameter int unsigned SAMPLE_BITS      = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    opcode_i,
  input  logic [6:0]                    note_number_i,
  input  logic [6:0]                    velocity_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] sample_o,
  output logic                          voice_busy_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [PADDR_W-1:0]            paddr,
  input  logic [PDATA_W-1:0]            pwdata,
  output logic [PDATA_W-1:0]            prdata,
  output logic                          pready
);

  cfg_t       cfg;
  dp_status_t status;
  uword_t     uw;
  logic       go;
  logic       accept;

  svr_apb_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  svr_useq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .opcode_i  (opcode_i),
    .status_i  (status),
    .in_ready_o(in_ready_o),
    .accept_o  (accept),
    .uw_o      (uw),
    .go_o      (go)
  );

  svr_datapath #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
    .PHASE_BITS      (PHASE_BITS),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .uw_i         (uw),
    .go_i         (go),
    .accept_i     (accept),
    .note_number_i(note_number_i),
    .velocity_i   (velocity_i),
    .out_ready_i  (out_ready_i),
    .status_o     (status),
    .out_valid_o  (out_valid_o),
    .sample_o     (sample_o),
    .voice_busy_o (voice_busy_o)
  );

endmodule

>>> verif/sine_voice_with_release_core_tb.sv
`timescale 1ns / 1ps

module sine_voice_with_release_core_tb;
  import svr_pkg::*;

  localparam int unsigned LUT_DEPTH = 1024;
  // 2^(k/12) in Q1.16, k counted from A
  localparam int unsigned SEMI_RATIO [12] = '{
    65536, 69433, 73562, 77936, 82570, 87480,
    92682, 98193, 104032, 110218, 116772, 123715
  };

  typedef struct packed {
    logic signed [15:0] sample;
    logic               busy;
  } voice_out_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [1:0]          opcode_i;
  logic [6:0]          note_number_i;
  logic [6:0]          velocity_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic signed [15:0]  sample_o;
  logic                voice_busy_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  int n_errors     = 0;
  int n_items      = 0;
  int snd_idle_pct = 22;
  int rcv_idle_pct = 79;

  voice_out_t pending_samples[$];

  // Register mirror
  logic [31:0] cfg_a4     = A4_INC_RST;
  logic [15:0] cfg_scale  = SCALE_RST;
  logic [15:0] cfg_factor = FACTOR_RST;
  logic [16:0] cfg_floor  = FLOOR_RST;

  // Voice state
  logic [31:0] acc_phase = '0;
  logic [31:0] step_inc  = '0;
  logic [15:0] level_q16 = '0;
  logic [16:0] rel_gain  = '0;
  logic        sounding  = 1'b0;

  int sine_lut [LUT_DEPTH];

  sine_voice_with_release_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .note_number_i (note_number_i),
    .velocity_i    (velocity_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .sample_o      (sample_o),
    .voice_busy_o  (voice_busy_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Quarter-wave Taylor series in Q30, truncated at every term
  initial begin : build_sine_lut
    logic [63:0] a, quad, rem, x, x2, t, s, mag;
    for (int i = 0; i < LUT_DEPTH; i++) begin
      a    = 64'(i) * 4;
      quad = a / LUT_DEPTH;
      rem  = a % LUT_DEPTH;
      if (quad[0]) rem = LUT_DEPTH - rem;
      x  = rem * HALF_PI_Q30 / LUT_DEPTH;
      x2 = (x * x) >> 30;
      t  = Q30_ONE - x2 / 110;
      t  = Q30_ONE - ((x2 * t) >> 30) / 72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 6;
      s  = (x * t) >> 30;
      mag = (s + (64'd1 << 14)) >> 15;
      if (mag > 64'd32767) mag = 64'd32767;
      sine_lut[i] = (quad >= 2) ? -int'(mag) : int'(mag);
    end
  end

  // Advance the voice by one transaction; returns 0 when the item is ignored
  function automatic bit voice_model(op_e op, logic [6:0] note, logic [6:0] vel);
    logic [7:0]  s;
    logic [3:0]  octv;
    logic [63:0] prod;
    logic [63:0] mag;
    int          rv;
    voice_out_t  res;
    case (op)
      OP_NOTE_ON: begin
        s    = {1'b0, note} + 8'd3;
        octv = 4'(s / 12);
        prod = 64'(cfg_a4) * 64'(SEMI_RATIO[s % 12]);
        prod = prod >> (22 - octv);
        if (prod > 64'hFFFF_FFFF) prod = 64'hFFFF_FFFF;
        acc_phase = '0;
        step_inc  = prod[31:0];
        level_q16 = 16'((32'(vel) * 32'(cfg_scale)) / 127);
        rel_gain  = '0;
        sounding  = 1'b1;
        return 1'b1;
      end
      OP_OFF_RELEASE: begin
        if (sounding && rel_gain == '0) begin
          rel_gain = GAIN_ONE;
          return 1'b1;
        end
        return 1'b0;
      end
      OP_OFF_NOW: begin
        res.busy = sounding;
        sounding = 1'b0;
        step_inc = '0;
        rel_gain = '0;
        return res.busy;
      end
      default: begin
        res = '0;
        if (sounding) begin
          rv  = sine_lut[acc_phase[31:22]];
          mag = (rv < 0) ? 64'(-rv) : 64'(rv);
          mag = (mag * 64'(level_q16)) >> 16;
          if (rel_gain != '0) mag = (mag * 64'(rel_gain)) >> 16;
          res.sample = (rv < 0) ? -mag[15:0] : mag[15:0];
          acc_phase  = acc_phase + step_inc;
          if (rel_gain != '0) begin
            rel_gain = 17'((64'(rel_gain) * 64'(cfg_factor)) >> 16);
            if (rel_gain <= cfg_floor) begin
              sounding = 1'b0;
              step_inc = '0;
              rel_gain = '0;
            end
          end
          res.busy = sounding;
        end
        pending_samples.push_back(res);
        return 1'b1;
      end
    endcase
  endfunction

  always @(posedge clk_i) begin : chk_sample
    voice_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected sample transaction: expected none, actual sample %0d busy %0b",
                 $time, sample_o, voice_busy_o);
        n_errors++;
      end else begin
        want = pending_samples.pop_front();
        if (sample_o !== want.sample) begin
          $display("%0t: sample mismatch: expected %0d, actual %0d",
                   $time, want.sample, sample_o);
          n_errors++;
        end
        if (voice_busy_o !== want.busy) begin
          $display("%0t: voice_busy mismatch: expected %0b, actual %0b",
                   $time, want.busy, voice_busy_o);
          n_errors++;
        end
      end
    end
    out_ready_i <= ($urandom_range(99) >= rcv_idle_pct);
  end

  task automatic send_item(op_e op, logic [6:0] note, logic [6:0] vel);
    int gap;
    in_valid_i    <= 1'b1;
    opcode_i      <= op;
    note_number_i <= note;
    velocity_i    <= vel;
    do @(posedge clk_i); while (!in_ready_o);
    if (voice_model(op, note, vel)) n_items++;
    gap = 0;
    while ($urandom_range(99) < snd_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_tick();
    send_item(OP_TICK, 7'($urandom), 7'($urandom));
  endtask

  // Drop valid, drain every expected sample, then let any note event finish
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] value);
    logic [31:0] mask;
    case (idx)
      REG_A4_INC: mask = 32'hFFFF_FFFF;
      REG_FLOOR:  mask = 32'h0001_FFFF;
      default:    mask = 32'h0000_FFFF;
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_A4_INC: cfg_a4     = value;
      REG_SCALE:  cfg_scale  = value[15:0];
      REG_FACTOR: cfg_factor = value[15:0];
      default:    cfg_floor  = value[16:0];
    endcase
    // read back through the same port
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== (value & mask)) begin
      $display("%0t: register %s read back: expected %0h, actual %0h",
               $time, idx.name(), value & mask, prdata);
      n_errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_random_settings();
    logic [31:0] a4;
    case ($urandom_range(5))
      0:       a4 = 32'hFFFF_FFFF;
      1:       a4 = 32'd1;
      2:       a4 = $urandom_range(32'hFFFF_FFFF, 1);
      default: a4 = $urandom_range(200_000_000, 1_000_000);
    endcase
    write_reg(REG_A4_INC, a4);
    case ($urandom_range(5))
      0:       write_reg(REG_SCALE, 32'd0);
      1:       write_reg(REG_SCALE, 32'd65535);
      default: write_reg(REG_SCALE, $urandom_range(65535));
    endcase
    case ($urandom_range(7))
      0:       write_reg(REG_FACTOR, 32'd0);
      1:       write_reg(REG_FACTOR, 32'd65535);
      default: write_reg(REG_FACTOR, $urandom_range(62000, 20000));
    endcase
    case ($urandom_range(7))
      0:       write_reg(REG_FLOOR, 32'd0);
      1:       write_reg(REG_FLOOR, 32'd65536);
      default: write_reg(REG_FLOOR, $urandom_range(4000));
    endcase
  endtask

  task automatic test_idle_voice();
    send_item(OP_TICK, 7'd0, 7'd0);
    send_item(OP_OFF_RELEASE, 7'd127, 7'd127);
    send_item(OP_OFF_NOW, 7'd0, 7'd127);
    send_item(OP_TICK, 7'd127, 7'd127);
    send_item(OP_NOTE_ON, 7'd0, 7'd127);
    repeat (3) send_tick();
    send_item(OP_OFF_RELEASE, 7'd0, 7'd0);
    repeat (2) send_tick();
    // second release request must keep the decayed gain
    send_item(OP_OFF_RELEASE, 7'd0, 7'd0);
    send_tick();
    send_item(OP_OFF_NOW, 7'd0, 7'd0);
    send_tick();
    send_item(OP_NOTE_ON, 7'd127, 7'd0);
    repeat (2) send_tick();
    send_item(OP_NOTE_ON, 7'd69, 7'd100);
    repeat (3) send_tick();
    send_item(OP_OFF_NOW, 7'd0, 7'd0);
    send_tick();
  endtask

  task automatic test_register_extremes();
    wait_quiet();
    write_reg(REG_A4_INC, 32'hFFFF_FFFF);
    write_reg(REG_SCALE, 32'd65535);
    write_reg(REG_FACTOR, 32'd0);
    write_reg(REG_FLOOR, 32'd0);
    send_item(OP_NOTE_ON, 7'd127, 7'd127);
    repeat (2) send_tick();
    send_item(OP_OFF_RELEASE, 7'd0, 7'd0);
    repeat (2) send_tick();
    send_item(OP_NOTE_ON, 7'd100, 7'd1);
    send_tick();
    wait_quiet();
    // step rounds to zero: voice holds the first table entry
    write_reg(REG_A4_INC, 32'd1);
    write_reg(REG_FACTOR, 32'd65535);
    write_reg(REG_FLOOR, 32'd65536);
    send_item(OP_NOTE_ON, 7'd0, 7'd127);
    repeat (3) send_tick();
    send_item(OP_OFF_RELEASE, 7'd0, 7'd0);
    repeat (2) send_tick();
  endtask

  task automatic test_random_traffic(int snd, int rcv, int n_target);
    int n_start;
    repeat (2) begin
      wait_quiet();
      snd_idle_pct = snd;
      rcv_idle_pct = rcv;
      load_random_settings();
      n_start = n_items;
      while (n_items - n_start < n_target / 2) begin
        if ($urandom_range(99) < 80) begin
          send_item(OP_NOTE_ON, 7'($urandom), 7'($urandom));
          repeat ($urandom_range(20, 1)) send_tick();
          case ($urandom_range(9))
            0: begin
              send_item(OP_OFF_NOW, 7'($urandom), 7'($urandom));
              repeat ($urandom_range(3)) send_tick();
            end
            1, 2: ;
            default: begin
              send_item(OP_OFF_RELEASE, 7'($urandom), 7'($urandom));
              // long tails let the release run down to the floor
              repeat ($urandom_range(($urandom_range(3) == 0) ? 150 : 40, 1)) send_tick();
            end
          endcase
        end else begin
          send_item(op_e'($urandom_range(3)), 7'($urandom), 7'($urandom));
        end
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    opcode_i      = OP_TICK;
    note_number_i = '0;
    velocity_i    = '0;
    out_ready_i   = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_voice();
    test_register_extremes();
    test_random_traffic(22, 79, 600);
    test_random_traffic(79, 22, 550);
    test_random_traffic(0, 0, 550);
    wait_quiet();
    repeat (10) @(posedge clk_i);

    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
